FILE: rtl/core/mes_pkg.sv
// ----------------------------------------------------------------------------
// mes_pkg
// Shared types and codes of the midpoint ellipse stepper.
// ----------------------------------------------------------------------------
package mes_pkg;

    // Command codes carried on the request word
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Control from the sequencer to the output stage
    typedef struct packed {
        logic load;   // current position is ready to be written out
        logic done;   // no further steps remain for this ellipse
    } mes_emit_t;

endpackage

FILE: rtl/core/mes_req_if.sv
// ----------------------------------------------------------------------------
// mes_req_if
// Request channel: one command word with centre and radii.
// ----------------------------------------------------------------------------
interface mes_req_if #(
    parameter int RADIUS_BITS = 9,
    parameter int COORD_BITS  = 12
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0]        radius_x;
    logic [RADIUS_BITS-1:0]        radius_y;

    modport source (
        output valid, cmd, center_x, center_y, radius_x, radius_y,
        input  ready
    );

    modport sink (
        input  valid, cmd, center_x, center_y, radius_x, radius_y,
        output ready
    );
endinterface

FILE: rtl/core/mes_pts_if.sv
// ----------------------------------------------------------------------------
// mes_pts_if
// Result channel: four symmetric points and the finished flag.
// ----------------------------------------------------------------------------
interface mes_pts_if #(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  pa_x;
    logic signed [COORD_BITS-1:0]  pa_y;
    logic signed [COORD_BITS-1:0]  pb_x;
    logic signed [COORD_BITS-1:0]  pb_y;
    logic signed [COORD_BITS-1:0]  pc_x;
    logic signed [COORD_BITS-1:0]  pc_y;
    logic signed [COORD_BITS-1:0]  pd_x;
    logic signed [COORD_BITS-1:0]  pd_y;
    logic                          done_res;

    modport source (
        output valid, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, done_res,
        input  ready
    );

    modport sink (
        input  valid, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, done_res,
        output ready
    );
endinterface

FILE: rtl/core/mes_mul.sv
// ----------------------------------------------------------------------------
// mes_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mes_mul #(
    parameter int OP_BITS = 22
) (
    input  logic                   clk,
    input  logic [OP_BITS-1:0]     a,
    input  logic [OP_BITS-1:0]     b,
    output logic [2*OP_BITS-1:0]   prod
);

    logic [2*OP_BITS-1:0] prod_reg;

    // product is ready in the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/mes_seq.sv
// ----------------------------------------------------------------------------
// mes_seq
// Sequencer and datapath: start set-up, region one/two iterations and the
// region-two entry, all multiplies going through one shared multiplier.
// ----------------------------------------------------------------------------
module mes_seq #(
    parameter int RADIUS_BITS = 9,
    parameter int COORD_BITS  = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mes_req_if.sink                       req,
    input  logic                          out_free,
    output mes_pkg::mes_emit_t            emit,
    output logic [RADIUS_BITS:0]          cur_x,
    output logic [RADIUS_BITS:0]          cur_y,
    output logic [COORD_BITS-1:0]         center_x,
    output logic [COORD_BITS-1:0]         center_y
);

    localparam int RB  = RADIUS_BITS;
    localparam int XYW = RB + 1;        // position width
    localparam int SQW = 2 * RB;        // radius squared
    localparam int MW  = 2 * RB + 4;    // multiplier operand width
    localparam int DW  = 4 * RB + 5;    // decision and distance width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_INIT,
        ST_CHK,
        ST_TX,
        ST_A,
        ST_TY,
        ST_B,
        ST_C,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        REG_DONE = 2'd0,
        REG_ONE  = 2'd1,
        REG_TWO  = 2'd2
    } region_t;

    state_t                 state_reg;
    region_t                region_reg;
    logic [XYW-1:0]         cur_x_reg;
    logic [XYW-1:0]         cur_y_reg;
    logic signed [DW-1:0]   dist_x_reg;
    logic signed [DW-1:0]   dist_y_reg;
    logic signed [DW-1:0]   dec_reg;
    logic signed [DW-1:0]   acc_reg;
    logic [COORD_BITS-1:0]  hcx_reg;
    logic [COORD_BITS-1:0]  hcy_reg;
    logic [RB-1:0]          hrx_reg;
    logic [RB-1:0]          hry_reg;
    logic [SQW-1:0]         rx2_reg;
    logic [SQW-1:0]         ry2_reg;

    logic [MW-1:0]          mul_a;
    logic [MW-1:0]          mul_b;
    logic [2*MW-1:0]        mul_q;
    logic signed [DW-1:0]   prod;

    logic signed [DW-1:0]   rx2_w;
    logic signed [DW-1:0]   ry2_w;

    // one-iteration results
    logic [XYW-1:0]         step_x;
    logic [XYW-1:0]         step_y;
    logic signed [DW-1:0]   step_dx;
    logic signed [DW-1:0]   step_dy;
    logic signed [DW-1:0]   step_dec;
    region_t                step_region;
    logic signed [DW-1:0]   quot;

    logic                   start_acc;
    logic                   step_acc;

    mes_mul #(
        .OP_BITS (MW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_q)
    );

    assign prod  = signed'(mul_q[DW-1:0]);
    assign rx2_w = signed'({{(DW-SQW){1'b0}}, rx2_reg});
    assign ry2_w = signed'({{(DW-SQW){1'b0}}, ry2_reg});

    assign start_acc = req.valid && (state_reg == ST_IDLE) && (req.cmd == mes_pkg::CMD_START);
    assign step_acc  = req.valid && (state_reg == ST_IDLE) && (req.cmd == mes_pkg::CMD_STEP);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_a = {{(MW-RB){1'b0}}, req.radius_x};
                mul_b = {{(MW-RB){1'b0}}, req.radius_x};
            end
            ST_SQX:
            begin
                mul_a = {{(MW-RB){1'b0}}, hry_reg};
                mul_b = {{(MW-RB){1'b0}}, hry_reg};
            end
            ST_SQY:
            begin
                mul_a = {4'b0, rx2_reg};
                mul_b = {{(MW-RB){1'b0}}, hry_reg};
            end
            ST_CHK:
            begin
                mul_a = {{(MW-XYW-1){1'b0}}, cur_x_reg, 1'b1};
                mul_b = {{(MW-XYW-1){1'b0}}, cur_x_reg, 1'b1};
            end
            ST_TX:
            begin
                mul_a = {4'b0, ry2_reg};
                mul_b = mul_q[MW-1:0];
            end
            ST_A:
            begin
                mul_a = {{(MW-XYW){1'b0}}, cur_y_reg - XYW'(1)};
                mul_b = {{(MW-XYW){1'b0}}, cur_y_reg - XYW'(1)};
            end
            ST_TY:
            begin
                mul_a = {4'b0, rx2_reg};
                mul_b = mul_q[MW-1:0];
            end
            ST_B:
            begin
                mul_a = {4'b0, rx2_reg};
                mul_b = {4'b0, ry2_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one iteration of the current region
    always_comb
    begin
        step_x      = cur_x_reg;
        step_y      = cur_y_reg;
        step_dx     = dist_x_reg;
        step_dy     = dist_y_reg;
        step_dec    = dec_reg;
        step_region = region_reg;
        unique case (region_reg)
            REG_ONE:
            begin
                step_x  = cur_x_reg + XYW'(1);
                step_dx = dist_x_reg + (ry2_w <<< 1);
                if (dec_reg[DW-1])
                begin
                    step_dec = dec_reg + step_dx + ry2_w;
                end
                else
                begin
                    step_y   = cur_y_reg - XYW'(1);
                    step_dy  = dist_y_reg - (rx2_w <<< 1);
                    step_dec = dec_reg + step_dx - step_dy + ry2_w;
                end
            end
            REG_TWO:
            begin
                step_y  = cur_y_reg - XYW'(1);
                step_dy = dist_y_reg - (rx2_w <<< 1);
                if (!dec_reg[DW-1])
                begin
                    step_dec = dec_reg - step_dy + rx2_w;
                end
                else
                begin
                    step_x   = cur_x_reg + XYW'(1);
                    step_dx  = dist_x_reg + (ry2_w <<< 1);
                    step_dec = dec_reg + step_dx - step_dy + rx2_w;
                end
                if (step_y == '0)
                begin
                    step_region = REG_DONE;
                end
            end
            default:
            begin
                step_region = region_reg;
            end
        endcase
    end

    // quarter-unit value divided by four, rounding toward zero
    always_comb
    begin
        quot = acc_reg >>> 2;
        if (acc_reg[DW-1] && (acc_reg[1:0] != 2'b00))
        begin
            quot = (acc_reg >>> 2) + DW'(1);
        end
    end

    // sequencer with its datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            region_reg <= REG_DONE;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            dist_x_reg <= '0;
            dist_y_reg <= '0;
            dec_reg    <= '0;
            acc_reg    <= '0;
            hcx_reg    <= '0;
            hcy_reg    <= '0;
            hrx_reg    <= '0;
            hry_reg    <= '0;
            rx2_reg    <= '0;
            ry2_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_acc)
                    begin
                        hcx_reg   <= req.center_x;
                        hcy_reg   <= req.center_y;
                        hrx_reg   <= req.radius_x;
                        hry_reg   <= req.radius_y;
                        cur_x_reg <= '0;
                        cur_y_reg <= {1'b0, req.radius_y};
                        state_reg <= ST_SQX;
                    end
                    else if (step_acc)
                    begin
                        cur_x_reg  <= step_x;
                        cur_y_reg  <= step_y;
                        dist_x_reg <= step_dx;
                        dist_y_reg <= step_dy;
                        dec_reg    <= step_dec;
                        region_reg <= step_region;
                        state_reg  <= (region_reg == REG_ONE) ? ST_CHK : ST_OUT;
                    end
                end
                ST_SQX:
                begin
                    rx2_reg   <= mul_q[SQW-1:0];
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    ry2_reg   <= mul_q[SQW-1:0];
                    state_reg <= ST_INIT;
                end
                ST_INIT:
                begin
                    // ry^2 + floor(rx^2/4) - rx^2*ry
                    dec_reg    <= ry2_w + (rx2_w >>> 2) - prod;
                    dist_x_reg <= '0;
                    dist_y_reg <= prod <<< 1;
                    state_reg  <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (dist_x_reg < dist_y_reg)
                    begin
                        region_reg <= REG_ONE;
                        state_reg  <= ST_OUT;
                    end
                    else if (cur_y_reg == '0)
                    begin
                        region_reg <= REG_DONE;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_TX;
                    end
                end
                ST_TX:
                begin
                    state_reg <= ST_A;
                end
                ST_A:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_TY;
                end
                ST_TY:
                begin
                    state_reg <= ST_B;
                end
                ST_B:
                begin
                    acc_reg   <= acc_reg + (prod <<< 2);
                    state_reg <= ST_C;
                end
                ST_C:
                begin
                    acc_reg   <= acc_reg - (prod <<< 2);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dec_reg    <= quot;
                    region_reg <= REG_TWO;
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign emit.load = (state_reg == ST_OUT) && out_free;
    assign emit.done = (region_reg == REG_DONE);
    assign cur_x     = cur_x_reg;
    assign cur_y     = cur_y_reg;
    assign center_x  = hcx_reg;
    assign center_y  = hcy_reg;

endmodule

FILE: rtl/core/midpoint_ellipse_stepper.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_stepper
// Two-region midpoint ellipse rasteriser, one iteration per command word.
// ----------------------------------------------------------------------------
// One command word is taken at a time; the block is busy until its result is
// in the output register. An advance in region two or when finished goes
// straight to output, one in region one via the region check; a start first
// squares both radii and forms the initial decision. On leaving region one,
// the region-two decision is formed before output. The single shared
// multiplier computes the squares and the region-two terms one product per
// cycle. A new command is taken while the previous result still waits in
// the output register; the block holds its next result until it is free.
// ----------------------------------------------------------------------------
module midpoint_ellipse_stepper #(
    parameter int RADIUS_BITS = 9,
    parameter int COORD_BITS  = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    mes_req_if.sink   req,
    mes_pts_if.source pts
);

    localparam int SW = COORD_BITS + RADIUS_BITS + 1;

    mes_pkg::mes_emit_t        emit;
    logic [RADIUS_BITS:0]      cur_x;
    logic [RADIUS_BITS:0]      cur_y;
    logic [COORD_BITS-1:0]     center_x;
    logic [COORD_BITS-1:0]     center_y;
    logic                      out_free;

    logic [SW-1:0]             xp_w;
    logic [SW-1:0]             xm_w;
    logic [SW-1:0]             yp_w;
    logic [SW-1:0]             ym_w;

    logic                      valid_reg;
    logic [COORD_BITS-1:0]     xp_reg;
    logic [COORD_BITS-1:0]     xm_reg;
    logic [COORD_BITS-1:0]     yp_reg;
    logic [COORD_BITS-1:0]     ym_reg;
    logic                      done_reg;

    mes_seq #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .emit     (emit),
        .cur_x    (cur_x),
        .cur_y    (cur_y),
        .center_x (center_x),
        .center_y (center_y)
    );

    assign out_free = !valid_reg || pts.ready;

    // symmetric coordinates, wrapping to the coordinate width
    assign xp_w = {{(SW-COORD_BITS){1'b0}}, center_x} + {{(SW-RADIUS_BITS-1){1'b0}}, cur_x};
    assign xm_w = {{(SW-COORD_BITS){1'b0}}, center_x} - {{(SW-RADIUS_BITS-1){1'b0}}, cur_x};
    assign yp_w = {{(SW-COORD_BITS){1'b0}}, center_y} + {{(SW-RADIUS_BITS-1){1'b0}}, cur_y};
    assign ym_w = {{(SW-COORD_BITS){1'b0}}, center_y} - {{(SW-RADIUS_BITS-1){1'b0}}, cur_y};

    // output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pts.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            xp_reg   <= xp_w[COORD_BITS-1:0];
            xm_reg   <= xm_w[COORD_BITS-1:0];
            yp_reg   <= yp_w[COORD_BITS-1:0];
            ym_reg   <= ym_w[COORD_BITS-1:0];
            done_reg <= emit.done;
        end
    end

    assign pts.valid    = valid_reg;
    assign pts.pa_x     = xp_reg;
    assign pts.pa_y     = yp_reg;
    assign pts.pb_x     = xp_reg;
    assign pts.pb_y     = ym_reg;
    assign pts.pc_x     = xm_reg;
    assign pts.pc_y     = yp_reg;
    assign pts.pd_x     = xm_reg;
    assign pts.pd_y     = ym_reg;
    assign pts.done_res = done_reg;

endmodule
